[rtl/mfud_pkg.sv]
// ----------------------------------------------------------------------------
// Motor feedback decoder package
// Shared widths, reset values, register indexes and stage types.
// ----------------------------------------------------------------------------
package mfud_pkg;

   localparam int RAW_W   = 16;
   localparam int SPAN_W  = 31;
   localparam int VAL_W   = 32;
   localparam int PROD_W  = RAW_W + SPAN_W;
   localparam int EST_W   = PROD_W + 1;
   localparam int REM_W   = RAW_W + 2;
   localparam int MULTI_W = 48;

   // Divisor of the scaling step (full scale of a raw code).
   localparam logic [REM_W-1:0] RAW_FULL_SCALE = 18'd65535;

   localparam logic [7:0]              MOTOR_ID_RST    = 8'd0;
   localparam logic [SPAN_W-1:0]       POS_SPAN_RST    = 31'd1647575;
   localparam logic signed [VAL_W-1:0] POS_MIN_RST     = -32'sd823788;
   localparam logic [SPAN_W-1:0]       SPEED_SPAN_RST  = 31'd4325376;
   localparam logic signed [VAL_W-1:0] SPEED_MIN_RST   = -32'sd2162688;
   localparam logic [SPAN_W-1:0]       TORQUE_SPAN_RST = 31'd1835008;
   localparam logic signed [VAL_W-1:0] TORQUE_MIN_RST  = -32'sd917504;

   typedef enum logic [2:0] {
      CSR_MOTOR_ID    = 3'd0,
      CSR_POS_SPAN    = 3'd1,
      CSR_POS_MIN     = 3'd2,
      CSR_SPEED_SPAN  = 3'd3,
      CSR_SPEED_MIN   = 3'd4,
      CSR_TORQUE_SPAN = 3'd5,
      CSR_TORQUE_MIN  = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_adv_type;

   typedef struct packed {
      logic [RAW_W-1:0] pos;
      logic [RAW_W-1:0] speed;
      logic [RAW_W-1:0] torque;
   } raw_codes_type;

endpackage

[rtl/mfud_if.sv]
// ----------------------------------------------------------------------------
// Motor feedback decoder channels
// Frame input, decoded result and register write channels.
// ----------------------------------------------------------------------------
interface mfud_req_if;
   logic        valid;
   logic        ready;
   logic        is_extended;
   logic [28:0] frame_id;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;
   logic [7:0]  byte4;
   logic [7:0]  byte5;

   modport source (output valid, is_extended, frame_id, byte0, byte1, byte2, byte3,
                   byte4, byte5, input ready);
   modport sink (input valid, is_extended, frame_id, byte0, byte1, byte2, byte3,
                 byte4, byte5, output ready);
endinterface

interface mfud_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        pos_raw;
   logic [15:0]        speed_raw;
   logic [15:0]        torque_raw;
   logic signed [31:0] pos_value;
   logic signed [31:0] speed_value;
   logic signed [31:0] torque_value;
   logic signed [31:0] pos_delta;
   logic signed [47:0] multi_turn_pos;

   modport source (output valid, pos_raw, speed_raw, torque_raw, pos_value, speed_value,
                   torque_value, pos_delta, multi_turn_pos, input ready);
   modport sink (input valid, pos_raw, speed_raw, torque_raw, pos_value, speed_value,
                 torque_value, pos_delta, multi_turn_pos, output ready);
endinterface

interface mfud_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/motor_feedback_unwrap_decoder.sv]
// ----------------------------------------------------------------------------
// Motor feedback decoder with multi-turn unwrap
// Filters feedback frames by motor id, scales the three codes and tracks a
// wrapping multi-turn position.
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  ---------+-----+------------------------------------------------------------
//  req_ch   | in  | extended flag, frame id, data bytes 0..5
//  rsp_ch   | out | raw codes, scaled values, position delta, multi-turn sum
//  csr_ch   | in  | register index and write data, always ready
//
// One frame is taken per cycle while the pipeline has room. A frame passes the
// multiply, divide and offset stages of the scalers and then the unwrap stage,
// which loads the result register and the turn state.
// Frames of other motors or with standard ids enter as bubbles.
// A stalled result holds each stage only once the stage after it is full.
// Reset restores the register defaults and clears the turn state.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_decoder #(
   parameter int SUM_WIDTH = 48
) (
   input  logic       clock,
   input  logic       reset,
   mfud_req_if.sink   req_ch,
   mfud_rsp_if.source rsp_ch,
   mfud_csr_if.sink   csr_ch
);
   import mfud_pkg::*;

   // Configuration registers
   logic [7:0]              motor_id_ff;
   logic [SPAN_W-1:0]       pos_span_ff, speed_span_ff, torque_span_ff;
   logic signed [VAL_W-1:0] pos_min_ff, speed_min_ff, torque_min_ff;

   // Pipeline control
   logic          v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic          rdy1, rdy2, rdy3, rdy4;
   logic          accept, match;
   stage_adv_type adv;

   raw_codes_type raw_in, raw1_ff, raw2_ff, raw3_ff;

   logic signed [VAL_W-1:0] pos_val, speed_val, torque_val;

   // Turn state
   logic [VAL_W-1:0]     prev_pos_ff;
   logic [SUM_WIDTH-1:0] turn_sum_ff, turn_sum_in;

   logic signed [VAL_W:0]   diff;
   logic signed [VAL_W+2:0] diff_x, twice_x, span_x, adj;
   logic [VAL_W-1:0]        delta;
   logic [64:0]             sum_ext_in, sum_ext_cur;

   // Result register
   raw_codes_type           rsp_raw_ff;
   logic signed [VAL_W-1:0] rsp_pos_ff, rsp_speed_ff, rsp_torque_ff, rsp_delta_ff;
   logic [MULTI_W-1:0]      rsp_multi_ff;

   // ---------------------------------------------------------------- config
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_id_ff    <= MOTOR_ID_RST;
         pos_span_ff    <= POS_SPAN_RST;
         pos_min_ff     <= POS_MIN_RST;
         speed_span_ff  <= SPEED_SPAN_RST;
         speed_min_ff   <= SPEED_MIN_RST;
         torque_span_ff <= TORQUE_SPAN_RST;
         torque_min_ff  <= TORQUE_MIN_RST;
      end else if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            CSR_MOTOR_ID:    motor_id_ff    <= csr_ch.data[7:0];
            CSR_POS_SPAN:    pos_span_ff    <= csr_ch.data[SPAN_W-1:0];
            CSR_POS_MIN:     pos_min_ff     <= $signed(csr_ch.data);
            CSR_SPEED_SPAN:  speed_span_ff  <= csr_ch.data[SPAN_W-1:0];
            CSR_SPEED_MIN:   speed_min_ff   <= $signed(csr_ch.data);
            CSR_TORQUE_SPAN: torque_span_ff <= csr_ch.data[SPAN_W-1:0];
            CSR_TORQUE_MIN:  torque_min_ff  <= $signed(csr_ch.data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   assign rdy4 = !rsp_valid_ff || rsp_ch.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_ch.ready = rdy1;
   assign accept = req_ch.valid && rdy1;
   assign match  = req_ch.is_extended && (req_ch.frame_id[15:8] == motor_id_ff);

   assign adv.s1 = rdy1;
   assign adv.s2 = rdy2;
   assign adv.s3 = rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff        <= accept && match;
         if (rdy2) v2_ff        <= v1_ff;
         if (rdy3) v3_ff        <= v2_ff;
         if (rdy4) rsp_valid_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------- scaling
   assign raw_in.pos    = {req_ch.byte0, req_ch.byte1};
   assign raw_in.speed  = {req_ch.byte2, req_ch.byte3};
   assign raw_in.torque = {req_ch.byte4, req_ch.byte5};

   always_ff @(posedge clock) begin
      if (adv.s1) raw1_ff <= raw_in;
      if (adv.s2) raw2_ff <= raw1_ff;
      if (adv.s3) raw3_ff <= raw2_ff;
   end

   mfud_scale u_pos_scale (
      .clock (clock),
      .adv   (adv),
      .raw   (raw_in.pos),
      .span  (pos_span_ff),
      .min_q (pos_min_ff),
      .value (pos_val)
   );

   mfud_scale u_speed_scale (
      .clock (clock),
      .adv   (adv),
      .raw   (raw_in.speed),
      .span  (speed_span_ff),
      .min_q (speed_min_ff),
      .value (speed_val)
   );

   mfud_scale u_torque_scale (
      .clock (clock),
      .adv   (adv),
      .raw   (raw_in.torque),
      .span  (torque_span_ff),
      .min_q (torque_min_ff),
      .value (torque_val)
   );

   // ---------------------------------------------------------------- unwrap
   always_comb begin
      diff    = {pos_val[VAL_W-1], pos_val} - {prev_pos_ff[VAL_W-1], prev_pos_ff};
      diff_x  = {{2{diff[VAL_W]}}, diff};
      twice_x = {diff[VAL_W], diff, 1'b0};
      span_x  = {4'd0, pos_span_ff};
      // Exactly half a span is left alone.
      if (twice_x > span_x) begin
         adj = diff_x - span_x;
      end else if (twice_x < -span_x) begin
         adj = diff_x + span_x;
      end else begin
         adj = diff_x;
      end
      delta       = adj[VAL_W-1:0];
      turn_sum_in = turn_sum_ff + {{(SUM_WIDTH-VAL_W){delta[VAL_W-1]}}, delta};
      sum_ext_in  = {{(65-SUM_WIDTH){1'b0}}, turn_sum_in};
      sum_ext_cur = {{(65-SUM_WIDTH){1'b0}}, turn_sum_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff <= '0;
         turn_sum_ff <= '0;
      end else if (rdy4 && v3_ff) begin
         prev_pos_ff <= $unsigned(pos_val);
         turn_sum_ff <= turn_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         rsp_raw_ff    <= raw3_ff;
         rsp_pos_ff    <= pos_val;
         rsp_speed_ff  <= speed_val;
         rsp_torque_ff <= torque_val;
         rsp_delta_ff  <= $signed(delta);
         rsp_multi_ff  <= sum_ext_in[MULTI_W-1:0];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pos_raw        = rsp_raw_ff.pos;
   assign rsp_ch.speed_raw      = rsp_raw_ff.speed;
   assign rsp_ch.torque_raw     = rsp_raw_ff.torque;
   assign rsp_ch.pos_value      = rsp_pos_ff;
   assign rsp_ch.speed_value    = rsp_speed_ff;
   assign rsp_ch.torque_value   = rsp_torque_ff;
   assign rsp_ch.pos_delta      = rsp_delta_ff;
   assign rsp_ch.multi_turn_pos = $signed(rsp_multi_ff);

   // ---------------------------------------------------------------- checks
   // The turn state always matches the last result that was loaded.
   a_prev_follows_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (prev_pos_ff == $unsigned(rsp_pos_ff)))
      else $error("previous position differs from the last result");

   a_sum_follows_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (sum_ext_cur[MULTI_W-1:0] == rsp_multi_ff))
      else $error("multi-turn sum differs from the last result");

   // The input only stalls when every stage is full and the result is held.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled with room in the pipeline");

   // A frame for another motor or with a standard id leaves a bubble.
   a_filtered_is_bubble: assert property (@(posedge clock) disable iff (reset)
      (accept && !match) |=> !v1_ff)
      else $error("filtered frame entered the pipeline");

endmodule

[rtl/mfud_scale.sv]
// ----------------------------------------------------------------------------
// Raw code scaler
// Three-stage lane: raw * span, division by 65535, then offset by the minimum.
// ----------------------------------------------------------------------------
module mfud_scale (
   input  logic                            clock,
   input  mfud_pkg::stage_adv_type         adv,
   input  logic [mfud_pkg::RAW_W-1:0]      raw,
   input  logic [mfud_pkg::SPAN_W-1:0]     span,
   input  logic signed [mfud_pkg::VAL_W-1:0] min_q,
   output logic signed [mfud_pkg::VAL_W-1:0] value
);
   import mfud_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VAL_W-1:0]  quot_ff, quot_in;
   logic [REM_W-1:0]  plo_ff, plo_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [EST_W-1:0]  est;
   logic [REM_W-1:0]  rem;
   logic [VAL_W-1:0]  quot_fix;

   assign prod_in = PROD_W'(raw) * PROD_W'(span);

   // 1/65535 is the series 2^-16 + 2^-32 + ...; the estimate is the true
   // quotient or one below it, so a single remainder check finishes it.
   assign est     = EST_W'(prod_ff) + EST_W'(prod_ff >> 16) + EST_W'(prod_ff >> 32);
   assign quot_in = est[EST_W-1:16];
   assign plo_in  = prod_ff[REM_W-1:0];

   // The remainder stays below twice the divisor, so its low bits are enough.
   assign rem      = plo_ff - {quot_ff[1:0], 16'd0} + quot_ff[REM_W-1:0];
   assign quot_fix = quot_ff + VAL_W'(rem >= RAW_FULL_SCALE);
   assign value_in = quot_fix + $unsigned(min_q);

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_ff <= prod_in;
      end
      if (adv.s2) begin
         quot_ff <= quot_in;
         plo_ff  <= plo_in;
      end
      if (adv.s3) begin
         value_ff <= value_in;
      end
   end

   assign value = $signed(value_ff);

endmodule

[tb/motor_feedback_unwrap_decoder_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor feedback decoder scoreboard
// Watches the frame, result and register channels. It keeps its own copy of
// the registers and the turn state, predicts the decoded result of every
// matching frame and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_decoder_checker #(
   parameter int SUM_W = 48
) (
   input  logic clock,
   input  logic reset,
   mfud_req_if  req_ch,
   mfud_rsp_if  rsp_ch,
   mfud_csr_if  csr_ch,
   output int   fail_count,
   output int   pending_count
);
   import mfud_pkg::*;

   typedef struct packed {
      logic [RAW_W-1:0]          pos_raw;
      logic [RAW_W-1:0]          speed_raw;
      logic [RAW_W-1:0]          torque_raw;
      logic signed [VAL_W-1:0]   pos_value;
      logic signed [VAL_W-1:0]   speed_value;
      logic signed [VAL_W-1:0]   torque_value;
      logic signed [VAL_W-1:0]   pos_delta;
      logic signed [MULTI_W-1:0] multi_turn_pos;
   } feedback_type;

   logic [7:0]              motor_id;
   logic [SPAN_W-1:0]       pos_span;
   logic [SPAN_W-1:0]       speed_span;
   logic [SPAN_W-1:0]       torque_span;
   logic [VAL_W-1:0]        pos_offset;
   logic [VAL_W-1:0]        speed_offset;
   logic [VAL_W-1:0]        torque_offset;
   logic signed [VAL_W-1:0] prior_pos;
   logic [SUM_W-1:0]        turn_total;
   feedback_type            expected_feedback[$];

   function automatic logic [VAL_W-1:0] scale_code(input logic [RAW_W-1:0] raw,
                                                   input logic [SPAN_W-1:0] span,
                                                   input logic [VAL_W-1:0] offset);
      logic [PROD_W-1:0] product;
      logic [PROD_W-1:0] quotient;
      product  = raw * span;
      quotient = product / 65535;
      return quotient[VAL_W-1:0] + offset;
   endfunction

   // Decodes one matching frame and advances the turn state.
   function automatic feedback_type decode_feedback(input logic [7:0] b0, b1, b2, b3, b4, b5);
      feedback_type fb;
      longint       step;
      longint       span_l;
      fb.pos_raw      = {b0, b1};
      fb.speed_raw    = {b2, b3};
      fb.torque_raw   = {b4, b5};
      fb.pos_value    = scale_code(fb.pos_raw, pos_span, pos_offset);
      fb.speed_value  = scale_code(fb.speed_raw, speed_span, speed_offset);
      fb.torque_value = scale_code(fb.torque_raw, torque_span, torque_offset);
      span_l = pos_span;
      step   = longint'(fb.pos_value) - longint'(prior_pos);
      // Exactly half a span is left alone on both sides.
      if (2 * step > span_l) begin
         step = step - span_l;
      end else if (2 * step < -span_l) begin
         step = step + span_l;
      end
      fb.pos_delta      = step[VAL_W-1:0];
      turn_total        = turn_total + {{(SUM_W-VAL_W){fb.pos_delta[VAL_W-1]}}, fb.pos_delta};
      fb.multi_turn_pos = MULTI_W'(turn_total);
      prior_pos         = fb.pos_value;
      return fb;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      feedback_type want;
      if (reset) begin
         motor_id      = MOTOR_ID_RST;
         pos_span      = POS_SPAN_RST;
         pos_offset    = POS_MIN_RST;
         speed_span    = SPEED_SPAN_RST;
         speed_offset  = SPEED_MIN_RST;
         torque_span   = TORQUE_SPAN_RST;
         torque_offset = TORQUE_MIN_RST;
         prior_pos     = '0;
         turn_total    = '0;
         expected_feedback.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_MOTOR_ID:    motor_id      = csr_ch.data[7:0];
               CSR_POS_SPAN:    pos_span      = csr_ch.data[SPAN_W-1:0];
               CSR_POS_MIN:     pos_offset    = csr_ch.data;
               CSR_SPEED_SPAN:  speed_span    = csr_ch.data[SPAN_W-1:0];
               CSR_SPEED_MIN:   speed_offset  = csr_ch.data;
               CSR_TORQUE_SPAN: torque_span   = csr_ch.data[SPAN_W-1:0];
               CSR_TORQUE_MIN:  torque_offset = csr_ch.data;
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_feedback.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing expected, expected none, got pos_raw 0x%0h",
                        $time, rsp_ch.pos_raw);
            end else begin
               want = expected_feedback.pop_front();
               check_field("pos_raw", want.pos_raw, rsp_ch.pos_raw);
               check_field("speed_raw", want.speed_raw, rsp_ch.speed_raw);
               check_field("torque_raw", want.torque_raw, rsp_ch.torque_raw);
               check_field("pos_value", want.pos_value, rsp_ch.pos_value);
               check_field("speed_value", want.speed_value, rsp_ch.speed_value);
               check_field("torque_value", want.torque_value, rsp_ch.torque_value);
               check_field("pos_delta", want.pos_delta, rsp_ch.pos_delta);
               check_field("multi_turn_pos", want.multi_turn_pos, rsp_ch.multi_turn_pos);
            end
         end
         // Standard-id frames and frames of other motors leave no trace.
         if (req_ch.valid && req_ch.ready && req_ch.is_extended
             && req_ch.frame_id[15:8] == motor_id) begin
            expected_feedback.push_back(decode_feedback(req_ch.byte0, req_ch.byte1,
                                                        req_ch.byte2, req_ch.byte3,
                                                        req_ch.byte4, req_ch.byte5));
         end
      end
      pending_count = expected_feedback.size();
   end

endmodule

[tb/motor_feedback_unwrap_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motor feedback decoder testbench
// Drives feedback frames in bursts against a stalling result sink, moves the
// registers through defaults, extremes and random settings between phases,
// runs a steady forward rotation at full rate, and reports the verdict of
// the scoreboard.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_decoder_tb;
   import mfud_pkg::*;

   localparam int SUM_W          = 48;
   localparam int IDLE_LIMIT     = 1000;
   localparam int RESULT_LATENCY = 4;
   localparam int SPIN_FRAMES    = 100;
   localparam logic [15:0] SPIN_STEP = 16'd32000;
   localparam logic [2:0]  CSR_SPARE_IDX = 3'd7;
   localparam logic [SPAN_W-1:0] SPAN_FULL = '1;
   localparam logic [VAL_W-1:0]  VAL_MAX   = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0]  VAL_MIN   = 32'h8000_0000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   rsp_full_rate;
   logic [7:0]  active_motor;
   logic [15:0] prior_pos_raw;

   mfud_req_if req_ch ();
   mfud_rsp_if rsp_ch ();
   mfud_csr_if csr_ch ();

   motor_feedback_unwrap_decoder #(.SUM_WIDTH(SUM_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   motor_feedback_unwrap_decoder_checker #(.SUM_W(SUM_W)) scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result sink: runs of full rate, light stalls, coin flips and heavy stalls.
   initial begin
      int mode;
      int run;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(8, 60);
         repeat (run) begin
            @(negedge clock);
            if (rsp_full_rate) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               case (mode)
                  0: rsp_ch.ready <= 1'b1;
                  1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                  default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [28:0] frame_id_for(input logic [7:0] motor);
      return {13'($urandom), motor, 8'($urandom)};
   endfunction

   function automatic logic [SPAN_W-1:0] random_span();
      if ($urandom_range(0, 1) != 0) begin
         return SPAN_W'($urandom);
      end
      return SPAN_W'($urandom_range(1, 8000000));
   endfunction

   task automatic drive_frame(input logic ext, input logic [28:0] id,
                              input logic [15:0] pos, speed, torque);
      req_ch.valid       <= 1'b1;
      req_ch.is_extended <= ext;
      req_ch.frame_id    <= id;
      req_ch.byte0       <= pos[15:8];
      req_ch.byte1       <= pos[7:0];
      req_ch.byte2       <= speed[15:8];
      req_ch.byte3       <= speed[7:0];
      req_ch.byte4       <= torque[15:8];
      req_ch.byte5       <= torque[7:0];
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Holds the sender until every expected result is out, then idles before the
   // next phase.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (RESULT_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic load_config(input logic [7:0] motor,
                              input logic [SPAN_W-1:0] p_span, input logic [VAL_W-1:0] p_min,
                              input logic [SPAN_W-1:0] s_span, input logic [VAL_W-1:0] s_min,
                              input logic [SPAN_W-1:0] t_span, input logic [VAL_W-1:0] t_min);
      write_reg(CSR_MOTOR_ID, {24'd0, motor});
      write_reg(CSR_POS_SPAN, {1'b0, p_span});
      write_reg(CSR_POS_MIN, p_min);
      write_reg(CSR_SPEED_SPAN, {1'b0, s_span});
      write_reg(CSR_SPEED_MIN, s_min);
      write_reg(CSR_TORQUE_SPAN, {1'b0, t_span});
      write_reg(CSR_TORQUE_MIN, t_min);
      csr_ch.valid <= 1'b0;
      active_motor = motor;
   endtask

   task automatic send_random_frame(output bit matched);
      int          pick;
      int          walk;
      logic        ext;
      logic [28:0] id;
      logic [15:0] pos;
      pick = $urandom_range(0, 99);
      walk = $urandom_range(0, 99);
      ext  = 1'b1;
      id   = frame_id_for(active_motor);
      if (pick < 6) begin
         ext = 1'b0;
         if (pick >= 3) begin
            id = 29'($urandom);
         end
      end else if (pick < 12) begin
         id[15:8] = active_motor ^ 8'($urandom_range(1, 255));
      end
      // A continuous walk so that the unwrap sees realistic motion, mixed with random
      // codes, jumps near half a turn and the end codes.
      if (walk < 35) begin
         pos = 16'($urandom);
      end else if (walk < 80) begin
         pos = prior_pos_raw + 16'($urandom_range(0, 4000)) - 16'd2000;
      end else if (walk < 90) begin
         pos = prior_pos_raw + 16'd32767 + 16'($urandom_range(0, 2));
      end else begin
         pos = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end
      matched = ext && (id[15:8] == active_motor);
      if (matched) begin
         prior_pos_raw = pos;
      end
      drive_frame(ext, id, pos, 16'($urandom), 16'($urandom));
   endtask

   task automatic run_random(input int count);
      int left;
      int burst;
      int gap_pick;
      bit matched;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && left > 0) begin
            send_random_frame(matched);
            if (matched) begin
               left--;
            end
            burst--;
         end
         gap_pick = $urandom_range(0, 19);
         if (gap_pick >= 8 && gap_pick < 19) begin
            pause_sender($urandom_range(1, 8));
         end else if (gap_pick == 19) begin
            drain_results();
         end
      end
   endtask

   initial begin
      logic [15:0] spin_pos;
      reset              = 1'b1;
      rsp_full_rate      = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.is_extended = 1'b0;
      req_ch.frame_id    = '0;
      req_ch.byte0       = '0;
      req_ch.byte1       = '0;
      req_ch.byte2       = '0;
      req_ch.byte3       = '0;
      req_ch.byte4       = '0;
      req_ch.byte5       = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
      active_motor       = MOTOR_ID_RST;
      prior_pos_raw      = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults. The first frame is unwrapped against a zero position.
      drive_frame(1'b1, frame_id_for(8'h00), 16'h8000, 16'h0000, 16'hFFFF);
      drive_frame(1'b0, frame_id_for(8'h00), 16'h1234, 16'h5678, 16'h9ABC);
      drive_frame(1'b1, frame_id_for(8'h01), 16'h4321, 16'h8765, 16'hCBA9);
      drive_frame(1'b1, frame_id_for(8'h00), 16'hFFFF, 16'hFFFF, 16'h0000);
      drive_frame(1'b1, frame_id_for(8'h00), 16'h0000, 16'h7FFF, 16'h8000);
      drive_frame(1'b1, frame_id_for(8'h00), 16'hFFF0, 16'h0001, 16'hFFFE);
      drive_frame(1'b1, {13'h1FFF, 8'h00, 8'hFF}, 16'h0010, 16'hA55A, 16'h5AA5);
      drive_frame(1'b1, 29'd0, 16'h0000, 16'h5AA5, 16'hA55A);
      prior_pos_raw = 16'h0000;
      run_random(90);
      drain_results();

      // A span of two makes exact half-span steps possible on both sides.
      write_reg(CSR_SPARE_IDX, $urandom);
      load_config(8'h5A, 31'd2, 32'd0, 31'd65535, 32'd0, 31'd1, 32'hFFFF_FFFF);
      drive_frame(1'b1, frame_id_for(8'h5A), 16'h0000, 16'h0000, 16'hFFFF);
      drive_frame(1'b1, frame_id_for(8'h5A), 16'hFFFF, 16'hFFFF, 16'h0000);
      drive_frame(1'b1, frame_id_for(8'h5A), 16'h8000, 16'h8000, 16'h7FFF);
      drive_frame(1'b1, frame_id_for(8'h5A), 16'hFFFF, 16'h0001, 16'hFFFF);
      drive_frame(1'b1, frame_id_for(8'h5A), 16'h0000, 16'hFFFE, 16'h0000);
      prior_pos_raw = 16'h0000;
      run_random(60);
      drain_results();

      // Largest spans and offsets: scaled values overflow the signed 32-bit range.
      load_config(8'hFF, SPAN_FULL, VAL_MAX, SPAN_FULL, VAL_MAX, SPAN_FULL, VAL_MAX);
      drive_frame(1'b1, frame_id_for(8'hFF), 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drive_frame(1'b1, frame_id_for(8'hFF), 16'h0000, 16'h0000, 16'h0000);
      drive_frame(1'b1, frame_id_for(8'hFF), 16'h7FFF, 16'h8000, 16'hFFFF);
      prior_pos_raw = 16'h7FFF;
      run_random(90);
      drain_results();

      // Steady forward rotation just under half a turn per frame, with the
      // result side taking every beat.
      write_reg(CSR_POS_MIN, 32'd0);
      csr_ch.valid <= 1'b0;
      rsp_full_rate = 1'b1;
      spin_pos = prior_pos_raw;
      for (int n = 0; n < SPIN_FRAMES; n++) begin
         spin_pos = spin_pos + SPIN_STEP;
         drive_frame(1'b1, frame_id_for(8'hFF), spin_pos, 16'($urandom), 16'($urandom));
      end
      drain_results();
      rsp_full_rate = 1'b0;
      prior_pos_raw = spin_pos;

      // Zero spans with the lowest offsets.
      load_config(8'h00, '0, VAL_MIN, '0, VAL_MIN, '0, VAL_MIN);
      drive_frame(1'b1, frame_id_for(8'h00), 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(50);
      drain_results();

      repeat (4) begin
         load_config(8'($urandom), random_span(), $urandom, random_span(), $urandom,
                     random_span(), $urandom);
         run_random(80);
         drain_results();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
